[rtl/byc_pkg.sv]
// shared types, constants and color arithmetic for the bgr to yuv converter
`default_nettype none

package byc_pkg;

    // output frame layouts
    typedef enum logic [1:0] {
        FMT_NV12 = 2'd0,
        FMT_YUY2 = 2'd1,
        FMT_I420 = 2'd2,
        FMT_BGR  = 2'd3
    } fmt_t;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam int unsigned SIZE_W   = 12;
    localparam int unsigned OFFSET_W = 24;

    localparam logic [1:0]        RESET_FORMAT = 2'd0;
    localparam logic [SIZE_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [SIZE_W-1:0] RESET_HEIGHT = 12'd480;

    // bt.601 studio range coefficients
    localparam int unsigned Y_R = 66;
    localparam int unsigned Y_G = 129;
    localparam int unsigned Y_B = 25;
    localparam int unsigned U_R = 38;
    localparam int unsigned U_G = 74;
    localparam int unsigned U_B = 112;
    localparam int unsigned V_R = 112;
    localparam int unsigned V_G = 94;
    localparam int unsigned V_B = 18;
    localparam int unsigned ROUND = 128;
    localparam int unsigned Y_OFS = 16;
    // rounding plus a bias that keeps the chroma sums positive and adds 128 after the shift
    localparam int unsigned C_BIAS = 128 + 32768;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [7:0]          byte_value;
        logic                last_of_run;
        logic                end_of_frame;
    } out_word_t;

    function automatic logic [7:0] luma_f(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
        logic [15:0] acc;
        acc = 16'(Y_R * 32'(r) + Y_G * 32'(g) + Y_B * 32'(b) + ROUND);
        return 8'(acc[15:8] + 8'(Y_OFS));
    endfunction

    function automatic logic [7:0] u_f(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        logic [16:0] acc;
        acc = 17'(U_B * 32'(b) + C_BIAS - U_R * 32'(r) - U_G * 32'(g));
        return acc[15:8];
    endfunction

    function automatic logic [7:0] v_f(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        logic [16:0] acc;
        acc = 17'(V_R * 32'(r) + C_BIAS - V_G * 32'(g) - V_B * 32'(b));
        return acc[15:8];
    endfunction

endpackage

`default_nettype wire

[rtl/bgr_to_yuv_format_converter_core.sv]
// bgr to yuv frame format converter: pixel pipeline, byte serializer and config registers
//
//  channel   ports                                   dir   moves
//  ------    -----                                   ---   -----
//  pixel     s_valid s_ready s_data(blue,green,red)  in    one raster pixel per word
//  byte      m_valid m_ready m_data                  out   one (offset, value) word
//  config    cfg_valid cfg_ready cfg_index cfg_data  in    one register write per word
//
// a pixel passes an input register, a math register and a four entry byte
// buffer; it yields 0 (yuy2 even column), 1, 3 or 4 byte words
// the byte port emits one word a cycle while m_ready is high; a pixel yields 4 or 0
// words for yuy2 odd or even column, 3 for bgr, 3 or 1 for nv12/i420; a new pixel
// is taken while the previous one is still draining
// a pixel's first byte word is offered once the pixel has gone through the input
// register and the math register into the byte buffer
// aresetn is synchronous: counters, valids and config registers clear, the held pixel and payload do not
// a stalled byte port backs up through the pipeline to s_ready; config is always ready
`default_nettype none

module bgr_to_yuv_format_converter_core
    import byc_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 2048,
    parameter int unsigned MAX_HEIGHT = 2048
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // pixel input
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pixel_t            s_data,
    // byte output
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_word_t              m_data,
    // configuration writes
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [SIZE_W-1:0] cfg_data
);

    // counter widths hold the largest size itself
    localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
    // common width for counter and size compares
    localparam int unsigned XW = 15;
    localparam int unsigned HW = SIZE_W - 1;
    localparam int unsigned PQ = 2 * HW;

    // clamp to 2..maxv and force even
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v,
                                                   input int unsigned maxv);
        int unsigned t;
        t = 32'(v);
        if (t < 2) begin
            t = 2;
        end
        if (t > maxv) begin
            t = maxv;
        end
        return SIZE_W'(t) & ~SIZE_W'(1);
    endfunction

    // ---------------- configuration ----------------
    fmt_t              fmt_reg, fmt_next;
    logic [SIZE_W-1:0] w_eff_reg, w_eff_next;
    logic [SIZE_W-1:0] h_eff_reg, h_eff_next;
    // (w/2)*(h/2): a quarter of the luma plane size
    logic [PQ-1:0]     plane_q_reg, plane_q_next;
    logic [SIZE_W-1:0] cfg_eff;

    assign cfg_ready = 1'b1;

    always_comb begin
        fmt_next     = fmt_reg;
        w_eff_next   = w_eff_reg;
        h_eff_next   = h_eff_reg;
        plane_q_next = plane_q_reg;
        cfg_eff      = '0;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_FORMAT: begin
                    fmt_next = fmt_t'(cfg_data[1:0]);
                end
                CFG_WIDTH: begin
                    cfg_eff      = eff_size(cfg_data, MAX_WIDTH);
                    w_eff_next   = cfg_eff;
                    plane_q_next = cfg_eff[SIZE_W-1:1] * h_eff_reg[SIZE_W-1:1];
                end
                CFG_HEIGHT: begin
                    cfg_eff      = eff_size(cfg_data, MAX_HEIGHT);
                    h_eff_next   = cfg_eff;
                    plane_q_next = w_eff_reg[SIZE_W-1:1] * cfg_eff[SIZE_W-1:1];
                end
                default: begin
                    // unused index: write is dropped
                end
            endcase
        end
    end

    // ---------------- position counters ----------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [XW-1:0] w_x, h_x, c_pre, r_inc, r_pre, c_inc, r_adv;
    logic          frame_last;
    logic          s_fire;

    always_comb begin
        w_x   = XW'(w_eff_reg);
        h_x   = XW'(h_eff_reg);
        // a counter left beyond a shrunken size wraps before the pixel is placed
        c_pre = (XW'(col_reg) >= w_x) ? '0 : XW'(col_reg);
        r_inc = (XW'(col_reg) >= w_x) ? XW'(row_reg) + XW'(1) : XW'(row_reg);
        r_pre = (r_inc >= h_x) ? '0 : r_inc;
        frame_last = (r_pre == h_x - XW'(1)) && (c_pre == w_x - XW'(1));
        // advance after the pixel
        c_inc = c_pre + XW'(1);
        r_adv = r_pre + XW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (s_fire) begin
            if (c_inc >= w_x) begin
                col_next = '0;
                row_next = (r_adv >= h_x) ? '0 : RW'(r_adv);
            end else begin
                col_next = CW'(c_inc);
                row_next = RW'(r_pre);
            end
        end
    end

    // ---------------- input register stage ----------------
    logic          s1_valid_reg;
    pixel_t        s1_pix_reg;
    pixel_t        s1_prev_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          s1_eof_reg;
    fmt_t          s1_fmt_reg;
    // previous pixel, first half of a yuy2 pair
    pixel_t        held_pixel_reg;

    // ---------------- math register stage ----------------
    logic              s2_valid_reg;
    fmt_t              s2_fmt_reg;
    pixel_t            s2_pix_reg;
    logic [CW-1:0]     s2_col_reg;
    logic              s2_row0_reg;
    logic              s2_eof_reg;
    logic [OFFSET_W-1:0] s2_p_reg;
    logic [7:0]        s2_y_cur_reg, s2_y_prev_reg;
    logic [7:0]        s2_u_cur_reg, s2_v_cur_reg;
    logic [7:0]        s2_u_avg_reg, s2_v_avg_reg;

    // ---------------- byte buffer ----------------
    out_word_t  buf_reg [4];
    out_word_t  buf_next [4];
    logic [2:0] buf_cnt_reg, buf_cnt_next;

    logic buf_free, s2_free, s2_fire, s1_fire, m_fire;

    assign m_fire   = m_valid && m_ready;
    assign buf_free = (buf_cnt_reg == 3'd0) || ((buf_cnt_reg == 3'd1) && m_ready);
    assign s2_fire  = s2_valid_reg && buf_free;
    assign s2_free  = !s2_valid_reg || buf_free;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign s_ready  = !s1_valid_reg || s2_free;
    assign s_fire   = s_valid && s_ready;

    // stage 1 to 2: color math and the row product
    logic [7:0]            ra, ga, ba;
    logic [RW+HW-2:0]      p_full;

    always_comb begin
        ra = 8'((9'(s1_prev_reg.red) + 9'(s1_pix_reg.red)) >> 1);
        ga = 8'((9'(s1_prev_reg.green) + 9'(s1_pix_reg.green)) >> 1);
        ba = 8'((9'(s1_prev_reg.blue) + 9'(s1_pix_reg.blue)) >> 1);
        // (row/2)*(width/2); row*width = 4p + (odd row ? width : 0)
        p_full = s1_row_reg[RW-1:1] * w_eff_reg[SIZE_W-1:1];
    end

    // stage 2 to buffer: byte offsets and the word list
    logic [OFFSET_W-1:0] row_off, pix_off, idx, plane, base;
    out_word_t           ent [4];
    logic [2:0]          ent_n;
    logic                chroma_site;

    always_comb begin
        plane   = {plane_q_reg, 2'b00};
        row_off = {s2_p_reg[OFFSET_W-3:0], 2'b00}
                + (s2_row0_reg ? OFFSET_W'(w_eff_reg) : '0);
        pix_off = row_off + OFFSET_W'(s2_col_reg);
        idx     = s2_p_reg + OFFSET_W'(s2_col_reg >> 1);
        base    = '0;
        chroma_site = !s2_row0_reg && !s2_col_reg[0];
        for (int i = 0; i < 4; i++) begin
            ent[i] = '0;
        end
        ent_n = 3'd0;
        unique case (s2_fmt_reg)
            FMT_NV12, FMT_I420: begin
                ent[0].byte_offset = pix_off;
                ent[0].byte_value  = s2_y_cur_reg;
                ent_n = 3'd1;
                if (chroma_site) begin
                    ent_n = 3'd3;
                    ent[1].byte_value = s2_u_cur_reg;
                    ent[2].byte_value = s2_v_cur_reg;
                    if (s2_fmt_reg == FMT_NV12) begin
                        // interleaved chroma after the luma plane
                        ent[1].byte_offset = plane + {idx[OFFSET_W-2:0], 1'b0};
                        ent[2].byte_offset = plane + {idx[OFFSET_W-2:0], 1'b1};
                    end else begin
                        // separate u and v planes
                        ent[1].byte_offset = plane + idx;
                        ent[2].byte_offset = plane + OFFSET_W'(plane_q_reg) + idx;
                    end
                end
            end
            FMT_YUY2: begin
                // the pair is written on its odd pixel as y0 u y1 v
                base = {pix_off[OFFSET_W-2:0] - (OFFSET_W-1)'(1), 1'b0};
                ent[0].byte_offset = base;
                ent[0].byte_value  = s2_y_prev_reg;
                ent[1].byte_offset = base + OFFSET_W'(1);
                ent[1].byte_value  = s2_u_avg_reg;
                ent[2].byte_offset = base + OFFSET_W'(2);
                ent[2].byte_value  = s2_y_cur_reg;
                ent[3].byte_offset = base + OFFSET_W'(3);
                ent[3].byte_value  = s2_v_avg_reg;
                ent_n = s2_col_reg[0] ? 3'd4 : 3'd0;
            end
            FMT_BGR: begin
                base = {pix_off[OFFSET_W-2:0], 1'b0} + pix_off;
                ent[0].byte_offset = base;
                ent[0].byte_value  = s2_pix_reg.blue;
                ent[1].byte_offset = base + OFFSET_W'(1);
                ent[1].byte_value  = s2_pix_reg.green;
                ent[2].byte_offset = base + OFFSET_W'(2);
                ent[2].byte_value  = s2_pix_reg.red;
                ent_n = 3'd3;
            end
            default: begin
                ent_n = 3'd0;
            end
        endcase
        // flags go on the last word of the pixel
        for (int i = 0; i < 4; i++) begin
            if (3'(i) + 3'd1 == ent_n) begin
                ent[i].last_of_run  = 1'b1;
                ent[i].end_of_frame = s2_eof_reg;
            end
        end
    end

    // buffer: shift out at the head, load a whole pixel when empty or emptying
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            buf_next[i] = buf_reg[i];
        end
        buf_cnt_next = buf_cnt_reg;
        if (m_fire) begin
            for (int i = 0; i < 3; i++) begin
                buf_next[i] = buf_reg[i + 1];
            end
            buf_cnt_next = buf_cnt_reg - 3'd1;
        end
        if (s2_fire) begin
            for (int i = 0; i < 4; i++) begin
                buf_next[i] = ent[i];
            end
            buf_cnt_next = ent_n;
        end
    end

    assign m_valid = (buf_cnt_reg != 3'd0);
    assign m_data  = buf_reg[0];

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg      <= fmt_t'(RESET_FORMAT);
            w_eff_reg    <= RESET_WIDTH;
            h_eff_reg    <= RESET_HEIGHT;
            plane_q_reg  <= PQ'(RESET_WIDTH[SIZE_W-1:1] * RESET_HEIGHT[SIZE_W-1:1]);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            buf_cnt_reg  <= 3'd0;
        end else begin
            fmt_reg      <= fmt_next;
            w_eff_reg    <= w_eff_next;
            h_eff_reg    <= h_eff_next;
            plane_q_reg  <= plane_q_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_fire) begin
                s2_valid_reg <= 1'b0;
            end
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            held_pixel_reg <= s_data;
            s1_pix_reg     <= s_data;
            s1_prev_reg    <= held_pixel_reg;
            s1_col_reg     <= CW'(c_pre);
            s1_row_reg     <= RW'(r_pre);
            s1_eof_reg     <= frame_last;
            s1_fmt_reg     <= fmt_reg;
        end
        if (s1_fire) begin
            s2_fmt_reg    <= s1_fmt_reg;
            s2_pix_reg    <= s1_pix_reg;
            s2_col_reg    <= s1_col_reg;
            s2_row0_reg   <= s1_row_reg[0];
            s2_eof_reg    <= s1_eof_reg;
            s2_p_reg      <= OFFSET_W'(p_full);
            s2_y_cur_reg  <= luma_f(s1_pix_reg.red, s1_pix_reg.green, s1_pix_reg.blue);
            s2_y_prev_reg <= luma_f(s1_prev_reg.red, s1_prev_reg.green, s1_prev_reg.blue);
            s2_u_cur_reg  <= u_f(s1_pix_reg.red, s1_pix_reg.green, s1_pix_reg.blue);
            s2_v_cur_reg  <= v_f(s1_pix_reg.red, s1_pix_reg.green, s1_pix_reg.blue);
            s2_u_avg_reg  <= u_f(ra, ga, ba);
            s2_v_avg_reg  <= v_f(ra, ga, ba);
        end
        for (int i = 0; i < 4; i++) begin
            buf_reg[i] <= buf_next[i];
        end
    end

    // ---------------- assertions ----------------
    a_buf_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_cnt_reg <= 3'd4)
        else $error("byte buffer count beyond its depth");

    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.end_of_frame || m_data.last_of_run))
        else $error("end of frame on a word that does not close its pixel");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> s1_valid_reg)
        else $error("accepted pixel lost from the input register");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !buf_free) |=> s2_valid_reg)
        else $error("math stage dropped while the byte buffer was busy");

endmodule

`default_nettype wire
